### hw/rtl/beqp_pkg.sv
package beqp_pkg;

	localparam int NUM_QUEUED = 5;
	localparam int NUM_DIRECT = 4;
	localparam int EVT_W      = 4;

	// register indexes of the configuration port
	localparam logic [1:0] CFG_POLL_PERIOD = 2'd0;
	localparam logic [1:0] CFG_OVERTAP_THR = 2'd1;
	localparam logic [1:0] CFG_OVERTAP_PCT = 2'd2;

	localparam logic [15:0] POLL_PERIOD_RST = 16'd250;
	localparam logic [8:0]  OVERTAP_THR_RST = 9'd65;
	localparam logic [6:0]  OVERTAP_PCT_RST = 7'd60;

	// one classified tick, handed from the front to the back
	typedef struct packed {
		logic [NUM_QUEUED-1:0] main_chg;
		logic [NUM_QUEUED-1:0] main_lvl;
		logic                  poll;
		logic [NUM_DIRECT-1:0] dir_chg;
		logic [NUM_DIRECT-1:0] dir_lvl;
		logic [6:0]            chance;
		logic [2:0]            pairs;
	} cmd_t;

endpackage

### hw/rtl/beqp_ram.sv
module beqp_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/beqp_cmdq.sv
module beqp_cmdq import beqp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t pop_cmd
);

	cmd_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full    = (cnt_q == 2'd2);
	assign valid   = (cnt_q != 2'd0);
	assign pop_cmd = mem_q[rp_q];
	assign do_push = push & ~full;
	assign do_pop  = pop & valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= ~wp_q;
			end
			if (do_pop) begin
				rp_q <= ~rp_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### hw/rtl/beqp_front.sv
module beqp_front import beqp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  tick_valid,
	output logic                  tick_stall,
	input  logic [NUM_QUEUED-1:0] main_levels,
	input  logic [NUM_DIRECT-1:0] extra_levels,
	input  logic [6:0]            chance,
	input  logic [2:0]            extra_pairs,
	input  logic [15:0]           poll_period,
	output logic                  cmd_push,
	output cmd_t                  cmd,
	input  logic                  cmd_full
);

	logic [NUM_QUEUED-1:0] prev_main_q;
	logic [NUM_DIRECT-1:0] prev_extra_q;
	logic [15:0]           elapsed_q;
	logic [15:0]           elapsed_inc;
	logic                  poll;

	assign tick_stall = cmd_full;
	assign cmd_push   = tick_valid & ~cmd_full;

	// saturating tick counter; a period of zero polls every tick
	assign elapsed_inc = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
	assign poll        = (elapsed_inc >= poll_period);

	always_comb begin
		cmd.main_chg = main_levels ^ prev_main_q;
		cmd.main_lvl = main_levels;
		cmd.poll     = poll;
		cmd.dir_chg  = poll ? (extra_levels ^ prev_extra_q) : '0;
		cmd.dir_lvl  = extra_levels;
		cmd.chance   = chance;
		cmd.pairs    = extra_pairs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_main_q  <= '0;
			prev_extra_q <= '0;
			elapsed_q    <= '0;
		end else if (cmd_push) begin
			prev_main_q <= main_levels;
			elapsed_q   <= poll ? 16'd0 : elapsed_inc;
			if (poll) begin
				prev_extra_q <= extra_levels;
			end
		end
	end

endmodule

### hw/rtl/beqp_back.sv
module beqp_back import beqp_pkg::*; #(
	parameter int QUEUE_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  cmd_t       cmd,
	output logic       cmd_pop,
	input  logic [8:0] overtap_threshold,
	input  logic [6:0] overtap_percent,
	output logic       event_valid,
	input  logic       event_stall,
	output logic [3:0] button,
	output logic       pressed,
	output logic       last
);

	localparam int AW   = $clog2(QUEUE_DEPTH);
	localparam int CW   = $clog2(QUEUE_DEPTH + 1);
	localparam int CMPW = (CW > 9) ? CW : 9;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PUSH = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_EMIT = 3'd3;
	localparam logic [2:0] ST_INJ  = 3'd4;
	localparam logic [2:0] ST_DIR  = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0]       st_q, st_d;
	cmd_t             cmd_q;
	logic [2:0]       idx_q, idx_d;
	logic [3:0]       inj_q, inj_d;
	logic [2:0]       inj_btn_q, inj_btn_d;
	logic [AW-1:0]    head_q, head_d;
	logic [AW-1:0]    tail_q, tail_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic             out_valid_q;
	logic [3:0]       button_q;
	logic             pressed_q;
	logic             last_q;

	logic             out_free;
	logic             emit;
	logic [3:0]       emit_btn;
	logic             emit_prs;
	logic             emit_last;
	logic             push_req;
	logic [2:0]       push_btn;
	logic             push_prs;
	logic             ram_we;
	logic             ram_re;
	logic [EVT_W-1:0] ram_rdata;
	logic             inject;
	logic [1:0]       dir_idx;

	assign out_free    = ~out_valid_q | ~event_stall;
	assign event_valid = out_valid_q;
	assign button      = button_q;
	assign pressed     = pressed_q;
	assign last        = last_q;
	assign dir_idx     = idx_q[1:0];

	// injection test uses the count left after the pop
	assign inject = ram_rdata[0]
		& (CMPW'(cnt_q - CW'(1)) > CMPW'(overtap_threshold))
		& (cmd_q.chance < overtap_percent)
		& (cmd_q.pairs != 3'd0);

	assign ram_we = push_req & (cnt_q < CW'(QUEUE_DEPTH));

	beqp_ram #(
		.WIDTH(EVT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata ({push_btn, push_prs}),
		.re    (ram_re),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		st_d      = st_q;
		idx_d     = idx_q;
		inj_d     = inj_q;
		inj_btn_d = inj_btn_q;
		head_d    = head_q;
		tail_d    = tail_q;
		cnt_d     = cnt_q;
		cmd_pop   = 1'b0;
		emit      = 1'b0;
		emit_btn  = '0;
		emit_prs  = 1'b0;
		emit_last = 1'b0;
		push_req  = 1'b0;
		push_btn  = '0;
		push_prs  = 1'b0;
		ram_re    = 1'b0;

		case (st_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					idx_d   = '0;
					st_d    = ST_PUSH;
				end
			end
			ST_PUSH: begin
				push_req = cmd_q.main_chg[idx_q];
				push_btn = idx_q;
				push_prs = ~cmd_q.main_lvl[idx_q];
				if (idx_q == 3'(NUM_QUEUED - 1)) begin
					idx_d = '0;
					st_d  = cmd_q.poll ? ST_RD : ST_DONE;
				end else begin
					idx_d = idx_q + 3'd1;
				end
			end
			ST_RD: begin
				if (cnt_q != '0) begin
					ram_re = 1'b1;
					st_d   = ST_EMIT;
				end else begin
					st_d = ST_DIR;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_btn  = {1'b0, ram_rdata[3:1]};
					emit_prs  = ram_rdata[0];
					emit_last = (cmd_q.dir_chg == '0);
					head_d    = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
					cnt_d     = cnt_q - CW'(1);
					if (inject) begin
						inj_d     = {cmd_q.pairs, 1'b0};
						inj_btn_d = ram_rdata[3:1];
						st_d      = ST_INJ;
					end else begin
						st_d = ST_DIR;
					end
				end
			end
			ST_INJ: begin
				// release first, then press, for each pair
				push_req = 1'b1;
				push_btn = inj_btn_q;
				push_prs = inj_q[0];
				inj_d    = inj_q - 4'd1;
				if (inj_q == 4'd1) begin
					st_d = ST_DIR;
				end
			end
			ST_DIR: begin
				if (!cmd_q.dir_chg[dir_idx] || out_free) begin
					if (cmd_q.dir_chg[dir_idx]) begin
						emit      = 1'b1;
						emit_btn  = 4'(NUM_QUEUED) + {2'b00, dir_idx};
						emit_prs  = ~cmd_q.dir_lvl[dir_idx];
						emit_last = ((cmd_q.dir_chg >> (dir_idx + 2'd1)) == '0)
							|| (dir_idx == 2'(NUM_DIRECT - 1));
					end
					if (dir_idx == 2'(NUM_DIRECT - 1)) begin
						st_d = ST_DONE;
					end else begin
						idx_d = idx_q + 3'd1;
					end
				end
			end
			ST_DONE: begin
				st_d = ST_IDLE;
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase

		if (ram_we) begin
			tail_d = (tail_q == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + AW'(1);
			cnt_d  = cnt_q + CW'(1);
		end

		// queue is flushed at the end of a tick if it is at least one short of full
		if (st_q == ST_DONE && cnt_q >= CW'(QUEUE_DEPTH - 1)) begin
			head_d = '0;
			tail_d = '0;
			cnt_d  = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		inj_btn_q <= inj_btn_d;
		if (emit) begin
			button_q  <= emit_btn;
			pressed_q <= emit_prs;
			last_q    <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			idx_q       <= '0;
			inj_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q        <= st_d;
			idx_q       <= idx_d;
			inj_q       <= inj_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			cnt_q       <= cnt_d;
			out_valid_q <= emit | (out_valid_q & event_stall);
		end
	end

endmodule

### hw/rtl/button_event_queue_pacer_top.sv
// Button event pacer. Each accepted tick word carries sampled button levels;
// level changes on the five queued buttons go into an event ring, and on
// every poll one queued event is popped and emitted, followed by any level
// changes of the four direct buttons; "last" marks the final event of a tick.
// A two-entry command queue separates tick classification from queue work,
// so ticks are accepted while the back end is busy. The back end pushes one
// event per cycle through the single write port of the event store: a tick
// without a poll runs the push and done states; a poll also emits the head
// event if there is one, then pushes any injected events and scans the
// direct buttons. The store needs no clearing pass after reset.
module button_event_queue_pacer_top import beqp_pkg::*; #(
	parameter int QUEUE_DEPTH = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [15:0]           cfg_data,
	input  logic                  tick_valid,
	output logic                  tick_stall,
	input  logic [NUM_QUEUED-1:0] main_levels,
	input  logic [NUM_DIRECT-1:0] extra_levels,
	input  logic [6:0]            chance,
	input  logic [2:0]            extra_pairs,
	output logic                  event_valid,
	input  logic                  event_stall,
	output logic [3:0]            button,
	output logic                  pressed,
	output logic                  last
);

	logic [15:0] poll_period_q;
	logic [8:0]  overtap_thr_q;
	logic [6:0]  overtap_pct_q;
	logic        cmd_push;
	cmd_t        cmd_in;
	logic        cmd_full;
	logic        cmd_pop;
	logic        cmd_valid;
	cmd_t        cmd_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_period_q <= POLL_PERIOD_RST;
			overtap_thr_q <= OVERTAP_THR_RST;
			overtap_pct_q <= OVERTAP_PCT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_POLL_PERIOD: poll_period_q <= cfg_data;
				CFG_OVERTAP_THR: overtap_thr_q <= cfg_data[8:0];
				CFG_OVERTAP_PCT: overtap_pct_q <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	beqp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_stall   (tick_stall),
		.main_levels  (main_levels),
		.extra_levels (extra_levels),
		.chance       (chance),
		.extra_pairs  (extra_pairs),
		.poll_period  (poll_period_q),
		.cmd_push     (cmd_push),
		.cmd          (cmd_in),
		.cmd_full     (cmd_full)
	);

	beqp_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (cmd_in),
		.full     (cmd_full),
		.pop      (cmd_pop),
		.valid    (cmd_valid),
		.pop_cmd  (cmd_out)
	);

	beqp_back #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd_valid         (cmd_valid),
		.cmd               (cmd_out),
		.cmd_pop           (cmd_pop),
		.overtap_threshold (overtap_thr_q),
		.overtap_percent   (overtap_pct_q),
		.event_valid       (event_valid),
		.event_stall       (event_stall),
		.button            (button),
		.pressed           (pressed),
		.last              (last)
	);

endmodule
